[src/vlfp_pkg.sv]
// shared types and constants for the varint length frame parser
package vlfp_pkg;

  localparam int unsigned GROUP_BITS = 7;
  localparam int unsigned CONT_BIT = 7;
  localparam int unsigned CFG_W = 32;
  localparam int unsigned DECL_W = 32;
  localparam logic [CFG_W-1:0] MAX_PAYLOAD_RESET = 32'd65536;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_DROPPED = 2'd2,
    KIND_POISON  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        frame_type;
    logic [7:0]        payload_byte;
    logic              last;
    logic [DECL_W-1:0] declared_length;
  } res_t;

endpackage

[src/vlfp_byte_if.sv]
// input byte channel
interface vlfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

[src/vlfp_res_if.sv]
// result channel
interface vlfp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  frame_type;
  logic [7:0]  payload_byte;
  logic        last;
  logic [31:0] declared_length;

  modport source (output valid, output kind, output frame_type, output payload_byte,
                  output last, output declared_length, input ready);
  modport sink (input valid, input kind, input frame_type, input payload_byte,
                input last, input declared_length, output ready);
endinterface

[src/vlfp_parser.sv]
// frame header parser and payload tracker, one byte per cycle while accept_i is high
module vlfp_parser #(
  parameter int unsigned LENGTH_BITS      = 32,
  parameter int unsigned MAX_LENGTH_BYTES = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [7:0]                data_byte_i,
  input  logic [vlfp_pkg::CFG_W-1:0] max_payload_i,
  output logic                      res_valid_o,
  output vlfp_pkg::res_t            res_o
);
  import vlfp_pkg::*;

  localparam int unsigned SEEN_W = $clog2(MAX_LENGTH_BYTES + 1);
  localparam int unsigned SH_W   = $clog2(GROUP_BITS * MAX_LENGTH_BYTES);
  localparam int unsigned WIDE_W = LENGTH_BITS + GROUP_BITS * MAX_LENGTH_BYTES;
  localparam int unsigned CMP_W  = (LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W;

  typedef enum logic [2:0] {
    PH_TYPE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_SKIP    = 3'd3,
    PH_POISON  = 3'd4
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [7:0]             type_q, type_d;
  logic [LENGTH_BITS-1:0] acc_q, acc_d;
  logic [SEEN_W-1:0]      seen_q, seen_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;

  logic [SH_W-1:0]        shift;
  logic [WIDE_W-1:0]      chunk_wide;
  logic                   overflow;
  logic [LENGTH_BITS-1:0] acc_or;
  logic [SEEN_W-1:0]      seen_inc;
  logic [LENGTH_BITS-1:0] rem_dec;

  assign shift      = SH_W'(seen_q * GROUP_BITS);
  assign chunk_wide = WIDE_W'(data_byte_i[GROUP_BITS-1:0]) << shift;
  assign overflow   = |chunk_wide[WIDE_W-1:LENGTH_BITS];
  assign acc_or     = acc_q | chunk_wide[LENGTH_BITS-1:0];
  assign seen_inc   = seen_q + SEEN_W'(1);
  assign rem_dec    = rem_q - LENGTH_BITS'(1);

  always_comb begin
    phase_d     = phase_q;
    type_d      = type_q;
    acc_d       = acc_q;
    seen_d      = seen_q;
    rem_d       = rem_q;
    res_valid_o = 1'b0;
    res_o.kind            = KIND_PAYLOAD;
    res_o.frame_type      = type_q;
    res_o.payload_byte    = 8'd0;
    res_o.last            = 1'b1;
    res_o.declared_length = DECL_W'(acc_q);
    if (accept_i) begin
      case (phase_q)
        PH_TYPE: begin
          type_d  = data_byte_i;
          acc_d   = '0;
          seen_d  = '0;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          if (overflow) begin
            phase_d     = PH_POISON;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_POISON;
          end else begin
            acc_d  = acc_or;
            seen_d = seen_inc;
            res_o.declared_length = DECL_W'(acc_or);
            if (data_byte_i[CONT_BIT]) begin
              if (32'(seen_inc) >= MAX_LENGTH_BYTES) begin
                phase_d     = PH_POISON;
                res_valid_o = 1'b1;
                res_o.kind  = KIND_POISON;
              end
            end else if (CMP_W'(acc_or) > CMP_W'(max_payload_i)) begin
              rem_d       = acc_or;
              phase_d     = PH_SKIP;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_DROPPED;
            end else if (acc_or == '0) begin
              phase_d     = PH_TYPE;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_EMPTY;
            end else begin
              rem_d   = acc_or;
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          rem_d              = rem_dec;
          res_valid_o        = 1'b1;
          res_o.payload_byte = data_byte_i;
          res_o.last         = (rem_dec == '0);
          if (rem_dec == '0) begin
            phase_d = PH_TYPE;
          end
        end
        PH_SKIP: begin
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PH_TYPE;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      type_q  <= '0;
      acc_q   <= '0;
      seen_q  <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      rem_q   <= rem_d;
    end
  end

  // poisoned stream holds until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_POISON |=> phase_q == PH_POISON)
    else $error("poison state left without reset");

  // every accepted payload byte yields a payload result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == PH_PAYLOAD |-> res_valid_o && res_o.kind == KIND_PAYLOAD)
    else $error("payload byte without result");

  // non-payload results always close a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind != KIND_PAYLOAD |-> res_o.last)
    else $error("status result without last");

  // byte counter never runs dry inside a payload or skip
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD || phase_q == PH_SKIP |-> rem_q != '0)
    else $error("remaining count zero in body phase");

endmodule

[src/vlfp_out_buf.sv]
// two-entry result buffer decoupling the parser from the result channel
module vlfp_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vlfp_pkg::res_t push_data_i,
  output logic           space_o,
  output logic           valid_o,
  input  logic           ready_i,
  output vlfp_pkg::res_t data_o
);
  import vlfp_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  res_t             mem_q [DEPTH];
  logic [CNT_W-1:0] count_q, count_d;
  logic             rd_ptr_q, wr_ptr_q;
  logic             pop;

  assign space_o = (count_q != CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/varint_length_frame_parser.sv]
// top level: type / varint length / payload deframer
//
//  channel  dir  handshake      payload
//  byte_i   in   valid/ready    data_byte[7:0]
//  res_o    out  valid/ready    kind, frame_type, payload_byte, last, declared_length
//  cfg      in   cfg_we_i       cfg_wdata_i -> max_payload
//
// one byte per cycle while byte_i.ready is high; a byte's result enters the
// two-entry result buffer at the edge that takes the byte and, if the buffer is
// empty, shows on res_o from the next cycle; byte_i.ready drops only while the
// result buffer holds two results; reset clears parser state and the buffer
// and sets max_payload to 65536
module varint_length_frame_parser #(
  parameter int unsigned LENGTH_BITS      = 32,
  parameter int unsigned MAX_LENGTH_BYTES = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [vlfp_pkg::CFG_W-1:0] cfg_wdata_i,
  vlfp_byte_if.sink                  byte_i,
  vlfp_res_if.source                 res_o
);
  import vlfp_pkg::*;

  logic [CFG_W-1:0] max_payload_q;
  logic             accept;
  logic             space;
  logic             res_valid;
  res_t             res;
  res_t             buf_data;

  assign byte_i.ready = space;
  assign accept       = byte_i.valid && space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RESET;
    end else if (cfg_we_i) begin
      max_payload_q <= cfg_wdata_i;
    end
  end

  vlfp_parser #(
    .LENGTH_BITS      (LENGTH_BITS),
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (byte_i.data_byte),
    .max_payload_i (max_payload_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  vlfp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .valid_o     (res_o.valid),
    .ready_i     (res_o.ready),
    .data_o      (buf_data)
  );

  assign res_o.kind            = buf_data.kind;
  assign res_o.frame_type      = buf_data.frame_type;
  assign res_o.payload_byte    = buf_data.payload_byte;
  assign res_o.last            = buf_data.last;
  assign res_o.declared_length = buf_data.declared_length;

endmodule
